@@ hw/rtl/zigzag_block_reorder_defines.svh @@
// Assertion macros for the block's sequencer, zbr_ctrl.
// Each expects clk and rst in scope.
`ifndef ZIGZAG_BLOCK_REORDER_DEFINES_SVH
`define ZIGZAG_BLOCK_REORDER_DEFINES_SVH

// Same-cycle implication.
`define ZBR_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define ZBR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

@@ hw/rtl/zbr_pkg.sv @@
package zbr_pkg;

  localparam int COEF_WIDTH = 16;
  localparam int BLOCK_LEN  = 64;
  localparam int ADDR_W     = 6;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(BLOCK_LEN - 1);

  // Register indexes
  localparam logic [1:0] REG_DIRECTION = 2'd0;

  // Direction codes
  localparam logic DIR_FORWARD = 1'b0;
  localparam logic DIR_INVERSE = 1'b1;

  typedef logic [ADDR_W-1:0] addr_tab_t [BLOCK_LEN];

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PRIME,
    ST_EMIT
  } zbr_state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_idx;
    logic              dir;
  } zbr_cmd_t;

  // Zigzag slot of each block position; entry 0 (DC) is unused.
  localparam addr_tab_t SCAN_TAB = '{
    6'd0,  6'd0,  6'd4,  6'd5,  6'd13, 6'd14, 6'd26, 6'd27,
    6'd1,  6'd3,  6'd6,  6'd12, 6'd15, 6'd25, 6'd28, 6'd41,
    6'd2,  6'd7,  6'd11, 6'd16, 6'd24, 6'd29, 6'd40, 6'd42,
    6'd8,  6'd10, 6'd17, 6'd23, 6'd30, 6'd39, 6'd43, 6'd52,
    6'd9,  6'd18, 6'd22, 6'd31, 6'd38, 6'd44, 6'd51, 6'd53,
    6'd19, 6'd21, 6'd32, 6'd37, 6'd45, 6'd50, 6'd54, 6'd59,
    6'd20, 6'd33, 6'd36, 6'd46, 6'd49, 6'd55, 6'd58, 6'd60,
    6'd34, 6'd35, 6'd47, 6'd48, 6'd56, 6'd57, 6'd61, 6'd62
  };

  // Forward: result j reads the block position whose slot is j-1.
  function automatic addr_tab_t build_fwd_addr();
    addr_tab_t t;
    for (int j = 0; j < BLOCK_LEN; j++) t[j] = '0;
    for (int k = 1; k < BLOCK_LEN; k++) t[SCAN_TAB[k] + 6'd1] = ADDR_W'(k);
    return t;
  endfunction

  // Inverse: result k reads arrival SCAN[k]+1; DC stays at 0.
  function automatic addr_tab_t build_inv_addr();
    addr_tab_t t;
    t[0] = '0;
    for (int k = 1; k < BLOCK_LEN; k++) t[k] = SCAN_TAB[k] + 6'd1;
    return t;
  endfunction

  localparam addr_tab_t FWD_ADDR = build_fwd_addr();
  localparam addr_tab_t INV_ADDR = build_inv_addr();

endpackage

@@ hw/rtl/zbr_coef_in_if.sv @@
interface zbr_coef_in_if #(
  parameter int COEF_WIDTH = zbr_pkg::COEF_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink (input valid, input coefficient, output ready);
endinterface

@@ hw/rtl/zbr_coef_out_if.sv @@
interface zbr_coef_out_if #(
  parameter int COEF_WIDTH = zbr_pkg::COEF_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [COEF_WIDTH-1:0] coefficient_out;
  logic                         is_dc;
  logic                         last;

  modport source (output valid, output coefficient_out, output is_dc, output last,
                  input ready);
  modport sink (input valid, input coefficient_out, input is_dc, input last,
                output ready);
endinterface

@@ hw/rtl/zbr_cfg.sv @@
module zbr_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [zbr_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [zbr_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [zbr_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic                                direction
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[3:2] == zbr_pkg::REG_DIRECTION);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= zbr_pkg::DIR_FORWARD;
    end else if (wr_hit) begin
      direction <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3:2] == zbr_pkg::REG_DIRECTION) begin
      prdata[0] = direction;
    end
  end

endmodule

@@ hw/rtl/zbr_ctrl.sv @@
`include "zigzag_block_reorder_defines.svh"

module zbr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              is_dc,
  output logic              last,
  input  logic              direction,
  output zbr_pkg::zbr_cmd_t cmd
);

  zbr_pkg::zbr_state_t              state, state_next;
  logic [zbr_pkg::ADDR_W-1:0]       fill_cnt;
  logic [zbr_pkg::ADDR_W-1:0]       idx;
  logic                             dir_q;
  logic                             in_acc;
  logic                             out_acc;

  assign in_ready  = (state == zbr_pkg::ST_FILL);
  assign out_valid = (state == zbr_pkg::ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign is_dc     = (idx == '0);
  assign last      = (idx == zbr_pkg::LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= zbr_pkg::ST_FILL;
      fill_cnt <= '0;
      idx      <= '0;
      dir_q    <= zbr_pkg::DIR_FORWARD;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
      // Sample direction on the item that completes the block
      if (in_acc && (fill_cnt == zbr_pkg::LAST_POS)) begin
        dir_q <= direction;
      end
      if (cmd.rd_en) begin
        idx <= cmd.rd_idx;
      end
    end
  end

  always_comb begin
    state_next   = state;
    cmd.wr_en    = in_acc;
    cmd.wr_addr  = fill_cnt;
    cmd.rd_en    = 1'b0;
    cmd.rd_idx   = idx + 1'b1;
    cmd.dir      = dir_q;
    case (state)
      zbr_pkg::ST_FILL: begin
        if (in_acc && (fill_cnt == zbr_pkg::LAST_POS)) begin
          state_next = zbr_pkg::ST_PRIME;
        end
      end
      zbr_pkg::ST_PRIME: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = '0;
        state_next = zbr_pkg::ST_EMIT;
      end
      zbr_pkg::ST_EMIT: begin
        if (out_acc) begin
          if (last) begin
            state_next = zbr_pkg::ST_FILL;
          end else begin
            cmd.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_next = zbr_pkg::ST_FILL;
      end
    endcase
  end

  `ZBR_ASSERT_NOW(a_no_overlap, 1'b1, !(in_ready && out_valid), "load and emit overlap")
  `ZBR_ASSERT_NEXT(a_fill_to_prime, in_acc && (fill_cnt == zbr_pkg::LAST_POS),
                   state == zbr_pkg::ST_PRIME, "full block did not start emit")
  `ZBR_ASSERT_NEXT(a_last_to_fill, out_acc && last,
                   (state == zbr_pkg::ST_FILL) && (fill_cnt == '0), "block did not end clean")
  `ZBR_ASSERT_NOW(a_read_when_free, cmd.rd_en && (state == zbr_pkg::ST_EMIT),
                  out_ready && !last, "read overwrote a waiting item")

endmodule

@@ hw/rtl/zbr_datapath.sv @@
module zbr_datapath #(
  parameter int COEF_WIDTH = zbr_pkg::COEF_WIDTH
) (
  input  logic                         clk,
  input  zbr_pkg::zbr_cmd_t            cmd,
  input  logic signed [COEF_WIDTH-1:0] wr_data,
  output logic signed [COEF_WIDTH-1:0] rd_data
);

  logic [COEF_WIDTH-1:0]          mem [zbr_pkg::BLOCK_LEN];
  logic [zbr_pkg::ADDR_W-1:0]     rd_addr;

  assign rd_addr = (cmd.dir == zbr_pkg::DIR_INVERSE) ? zbr_pkg::INV_ADDR[cmd.rd_idx]
                                                     : zbr_pkg::FWD_ADDR[cmd.rd_idx];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= wr_data;
    end
  end

  // Hold the read word until the next read command
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/zigzag_block_reorder.sv @@
// Zigzag block reorder for one 8x8 block of quantized coefficients. Items
// arrive on coefs, 64 per block: in forward mode (direction = 0) in
// column-major order, and the block leaves on reordered as the DC term
// (is_dc high) followed by the 63 AC terms in transposed zigzag order; in
// inverse mode (direction = 1) the DC and 63 zigzag AC terms go in and the
// block leaves in column-major order. last marks the 64th item of a block.
// Direction is sampled on the item that completes a block; write it over
// the APB port (register 0, byte address 0) only while the block is idle.
// Timing: a block is loaded at one item per cycle while coefs is valid,
// then the prime state starts the read, then results leave at one per
// cycle when reordered is not stalled. The single block store, written
// while loading and read while emitting, keeps blocks from overlapping:
// coefs is held not ready while a block is being emitted.
module zigzag_block_reorder #(
  parameter int COEF_WIDTH = zbr_pkg::COEF_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  zbr_coef_in_if.sink                        coefs,
  zbr_coef_out_if.source                     reordered,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [zbr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [zbr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [zbr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  logic              direction;
  zbr_pkg::zbr_cmd_t cmd;

  // Configuration register
  zbr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .direction (direction)
  );

  // Sequencer: load count, emit index, read commands
  zbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coefs.valid),
    .in_ready  (coefs.ready),
    .out_valid (reordered.valid),
    .out_ready (reordered.ready),
    .is_dc     (reordered.is_dc),
    .last      (reordered.last),
    .direction (direction),
    .cmd       (cmd)
  );

  // Block store and registered read port that feeds the result item
  zbr_datapath #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .cmd     (cmd),
    .wr_data (coefs.coefficient),
    .rd_data (reordered.coefficient_out)
  );

endmodule
